// File: hdl/slpc_pkg.sv
// Package for the scanline layer priority compositor.
// Holds the configuration record, register indexes, reset values and pixel constants.
// No dependencies; every other file of the block imports it.
`default_nettype none

package slpc_pkg;

    // Widths of the stream payload
    localparam int LAYER_W  = 32;
    localparam int FLAGS_W  = 8;
    localparam int PIXEL_W  = 31;
    localparam int WORD_W   = 16;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_LAYER_ENABLES  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GFX_PRIORITY   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BG_PRIORITY    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TEXT_PRIORITY  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_VIDEO_CTRL     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_TRANSP_ENABLE  = 3'd5;

    // Reset values
    localparam logic [4:0] RST_LAYER_ENABLES = 5'd0;
    localparam logic [1:0] RST_GFX_PRIORITY  = 2'd0;
    localparam logic [1:0] RST_BG_PRIORITY   = 2'd1;
    localparam logic [1:0] RST_TEXT_PRIORITY = 2'd2;
    localparam logic [7:0] RST_VIDEO_CTRL    = 8'h00;
    localparam logic       RST_TRANSP_ENABLE = 1'b1;

    // Packed 16-bit word constants
    localparam logic [WORD_W-1:0] FIELD_LSB_CLEAR = 16'hF79E;
    localparam logic [WORD_W-1:0] IX2             = 16'h0040;

    // Video control mode decode
    localparam logic [7:0] VC_MODE_MASK = 8'h5D;
    localparam logic [7:0] VC_TRANSLUC  = 8'h1D;
    localparam logic [7:0] VC_DIM       = 8'h1C;
    localparam logic [7:0] VC_PRIO_MASK = 8'h5C;
    localparam logic [7:0] VC_PRIO      = 8'h14;
    localparam logic [7:0] VC_SP2_GATE  = 8'h10;

    typedef struct packed {
        logic [4:0] layer_enables;
        logic [1:0] gfx_priority;
        logic [1:0] bg_priority;
        logic [1:0] text_priority;
        logic [7:0] video_control_high;
        logic       transparency_enable;
    } slpc_cfg_t;

endpackage

`default_nettype wire

// File: hdl/slpc_in_if.sv
// Input pixel channel: four layer pixels, flag byte and scanline-end marker.
// Depends on slpc_pkg for payload widths.
`default_nettype none

interface slpc_in_if;
    import slpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [LAYER_W-1:0] gfx_pixel;
    logic [LAYER_W-1:0] special_gfx_pixel;
    logic [LAYER_W-1:0] second_special_pixel;
    logic [LAYER_W-1:0] bgtext_pixel;
    logic [FLAGS_W-1:0] layer_flags;
    logic               last_pixel;

    modport source (
        output valid, gfx_pixel, special_gfx_pixel, second_special_pixel,
               bgtext_pixel, layer_flags, last_pixel,
        input  ready
    );

    modport sink (
        input  valid, gfx_pixel, special_gfx_pixel, second_special_pixel,
               bgtext_pixel, layer_flags, last_pixel,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/slpc_out_if.sv
// Output pixel channel: composited RGB888 pixel with I marker and scanline-end marker.
// Depends on slpc_pkg for payload widths.
`default_nettype none

interface slpc_out_if;
    import slpc_pkg::*;

    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel_out;
    logic               last_out;

    modport source (
        output valid, pixel_out, last_out,
        input  ready
    );

    modport sink (
        input  valid, pixel_out, last_out,
        output ready
    );
endinterface

`default_nettype wire

// File: hdl/scanline_layer_priority_compositor.sv
// Top level of the scanline layer priority compositor.
// Depends on slpc_pkg, slpc_in_if, slpc_out_if, slpc_cfg_regs and slpc_compose.
//
// Usage:
//   pix_in carries one pixel item per handshake: four 32-bit layer pixels,
//   the layer flag byte and a scanline-end marker. pix_out returns exactly one
//   composited pixel per input item, in order, with last_out copied through.
//   Both channels use valid/ready; an item moves when both are high.
//   The accepting edge loads the input register; the composition result is
//   then loaded into the output register, where pix_out.valid rises.
//   Throughput is one pixel per cycle; the input register and the output
//   register each advance whenever the stage after them is free or draining.
//   When the receiver holds pix_out.ready low, the output item holds, the
//   input register fills, and pix_in.ready then drops until space opens.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data;
//   write them only while no pixels are in flight.
//   Reset empties both stages and loads the register defaults: all layers
//   off, graphics priority 0, background 1, text 2, control 0, transparency on.
`default_nettype none

module scanline_layer_priority_compositor (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [slpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [slpc_pkg::CFG_DATA_W-1:0] cfg_data,
    slpc_in_if.sink                              pix_in,
    slpc_out_if.source                           pix_out
);
    import slpc_pkg::*;

    slpc_cfg_t          cfg;

    logic               s1_valid_reg, s1_valid_next;
    logic [LAYER_W-1:0] s1_gfx_reg, s1_sp_reg, s1_sp2_reg, s1_bt_reg;
    logic [1:0]         s1_flags_reg;
    logic               s1_last_reg;

    logic               out_valid_reg, out_valid_next;
    logic [PIXEL_W-1:0] out_pixel_reg;
    logic               out_last_reg;

    logic [PIXEL_W-1:0] comp_pixel;
    logic               in_take, out_load;

    slpc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    slpc_compose u_compose (
        .cfg                  (cfg),
        .gfx_pixel            (s1_gfx_reg),
        .special_gfx_pixel    (s1_sp_reg),
        .second_special_pixel (s1_sp2_reg),
        .bgtext_pixel         (s1_bt_reg),
        .flags                (s1_flags_reg),
        .pixel                (comp_pixel)
    );

    // Stage handshakes
    assign out_load     = s1_valid_reg && (!out_valid_reg || pix_out.ready);
    assign pix_in.ready = !s1_valid_reg || out_load;
    assign in_take      = pix_in.valid && pix_in.ready;

    always_comb
    begin
        s1_valid_next  = in_take || (s1_valid_reg && !out_load);
        out_valid_next = out_load || (out_valid_reg && !pix_out.ready);
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_gfx_reg   <= pix_in.gfx_pixel;
            s1_sp_reg    <= pix_in.special_gfx_pixel;
            s1_sp2_reg   <= pix_in.second_special_pixel;
            s1_bt_reg    <= pix_in.bgtext_pixel;
            s1_flags_reg <= pix_in.layer_flags[1:0];
            s1_last_reg  <= pix_in.last_pixel;
        end
    end

    // Result register payload
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_pixel_reg <= comp_pixel;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign pix_out.valid     = out_valid_reg;
    assign pix_out.pixel_out = out_pixel_reg;
    assign pix_out.last_out  = out_last_reg;

endmodule

`default_nettype wire

// File: hdl/slpc_cfg_regs.sv
// Configuration register file of the compositor, written through a plain write port.
// Depends on slpc_pkg.
`default_nettype none

module slpc_cfg_regs (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_we,
    input  wire logic [slpc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [slpc_pkg::CFG_DATA_W-1:0] cfg_data,
    output slpc_pkg::slpc_cfg_t                  cfg
);
    import slpc_pkg::*;

    slpc_cfg_t cfg_reg;
    slpc_cfg_t cfg_next;

    // Decode a write into the addressed field
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_LAYER_ENABLES: cfg_next.layer_enables       = cfg_data[4:0];
                CFG_GFX_PRIORITY:  cfg_next.gfx_priority        = cfg_data[1:0];
                CFG_BG_PRIORITY:   cfg_next.bg_priority         = cfg_data[1:0];
                CFG_TEXT_PRIORITY: cfg_next.text_priority       = cfg_data[1:0];
                CFG_VIDEO_CTRL:    cfg_next.video_control_high  = cfg_data;
                CFG_TRANSP_ENABLE: cfg_next.transparency_enable = cfg_data[0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.layer_enables       <= RST_LAYER_ENABLES;
            cfg_reg.gfx_priority        <= RST_GFX_PRIORITY;
            cfg_reg.bg_priority         <= RST_BG_PRIORITY;
            cfg_reg.text_priority       <= RST_TEXT_PRIORITY;
            cfg_reg.video_control_high  <= RST_VIDEO_CTRL;
            cfg_reg.transparency_enable <= RST_TRANSP_ENABLE;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// File: hdl/slpc_compose.sv
// Per-pixel layer composition: pack to 16-bit words, draw layers in priority order,
// apply override or dim fill, expand back to RGB888. Purely combinational.
// Depends on slpc_pkg.
`default_nettype none

module slpc_compose (
    input  wire slpc_pkg::slpc_cfg_t                cfg,
    input  wire logic [slpc_pkg::LAYER_W-1:0]       gfx_pixel,
    input  wire logic [slpc_pkg::LAYER_W-1:0]       special_gfx_pixel,
    input  wire logic [slpc_pkg::LAYER_W-1:0]       second_special_pixel,
    input  wire logic [slpc_pkg::LAYER_W-1:0]       bgtext_pixel,
    input  wire logic [1:0]                         flags,
    output logic [slpc_pkg::PIXEL_W-1:0]            pixel
);
    import slpc_pkg::*;

    // RGB888 + marker bits to R5 G5 I B5; transparent packs to zero
    function automatic logic [WORD_W-1:0] pack565(input logic [LAYER_W-1:0] p);
        if (p[31])
            return '0;
        return {p[23:19], p[15:11], p[30], p[7:3]};
    endfunction

    function automatic logic [PIXEL_W-1:0] unpack565(input logic [WORD_W-1:0] w);
        logic [5:0] g6;
        g6 = {w[10:6], w[5]};
        return {w[5], 6'd0, w[15:11], w[15:13], g6, g6[5:4], w[4:0], w[4:2]};
    endfunction

    function automatic logic [WORD_W-1:0] blend_half(input logic [WORD_W-1:0] base,
                                                     input logic [WORD_W-1:0] top);
        logic [WORD_W-1:0] w;
        logic [WORD_W:0]   s;
        w = top & FIELD_LSB_CLEAR;
        if (base[5])
            w = w + IX2;
        s = {1'b0, base & FIELD_LSB_CLEAR} + {1'b0, w};
        return s[WORD_W:1];
    endfunction

    function automatic logic [WORD_W-1:0] draw_plain(input logic [WORD_W-1:0] d,
                                                     input logic [WORD_W-1:0] src,
                                                     input logic opaq);
        if (opaq || src != '0)
            return src;
        return d;
    endfunction

    function automatic logic [WORD_W-1:0] draw_gated(input logic [WORD_W-1:0] d,
                                                     input logic [WORD_W-1:0] line,
                                                     input logic [1:0] fl,
                                                     input logic opaq,
                                                     input logic td,
                                                     input logic [1:0] mask);
        if (opaq)
            return line;
        if (td)
            return (((fl & mask) != '0) && line != '0) ? line : d;
        return (line != '0) ? line : d;
    endfunction

    // bl is the half blend of the line with the special graphics word
    function automatic logic [WORD_W-1:0] draw_text_tr(input logic [WORD_W-1:0] d,
                                                       input logic [WORD_W-1:0] line,
                                                       input logic [1:0] fl,
                                                       input logic [WORD_W-1:0] sp,
                                                       input logic [WORD_W-1:0] bl,
                                                       input logic opaq);
        if (opaq)
        begin
            if (sp != '0)
                return bl;
            return fl[0] ? line : '0;
        end
        if (!fl[0] || line == '0)
            return d;
        return (sp != '0) ? bl : line;
    endfunction

    function automatic logic [WORD_W-1:0] draw_bg_tr(input logic [WORD_W-1:0] d,
                                                     input logic [WORD_W-1:0] line,
                                                     input logic [1:0] fl,
                                                     input logic [WORD_W-1:0] sp,
                                                     input logic [WORD_W-1:0] bl,
                                                     input logic opaq);
        if (opaq)
            return (sp != '0) ? bl : line;
        if (!fl[1] || line == '0)
            return d;
        return (sp != '0) ? bl : line;
    endfunction

    logic [WORD_W-1:0] g, sp, sp2, bt, bl;
    logic              gon, tron, pron, ton, bgon;
    logic              trm, dim, prm, sp2_gate;
    logic [1:0]        gp, spp, tp;
    logic [WORD_W-1:0] d;
    logic              opaq, td;

    // Layer words and mode decode
    assign g   = pack565(gfx_pixel);
    assign sp  = pack565(special_gfx_pixel);
    assign sp2 = pack565(second_special_pixel);
    assign bt  = pack565(bgtext_pixel);
    assign bl  = blend_half(bt, sp);

    assign gp   = cfg.gfx_priority;
    assign spp  = cfg.bg_priority;
    assign tp   = cfg.text_priority;
    assign gon  = cfg.layer_enables[0];
    assign tron = cfg.layer_enables[1] & cfg.transparency_enable;
    assign pron = cfg.layer_enables[2] & cfg.transparency_enable;
    assign ton  = cfg.layer_enables[3];
    assign bgon = cfg.layer_enables[4];
    assign trm  = (cfg.video_control_high & VC_MODE_MASK) == VC_TRANSLUC;
    assign dim  = (cfg.video_control_high & VC_MODE_MASK) == VC_DIM;
    assign prm  = (cfg.video_control_high & VC_PRIO_MASK) == VC_PRIO;
    assign sp2_gate = (cfg.video_control_high & VC_SP2_GATE) != '0;

    // Draw back to front: levels 2 and 3, then 1, then 0
    always_comb
    begin
        d    = '0;
        opaq = 1'b1;
        td   = 1'b0;

        // levels 2 and 3
        if (gp[1])
        begin
            if (gon)
            begin
                d = draw_plain(d, g, opaq);
                opaq = 1'b0;
            end
            if (tron)
            begin
                d = draw_plain(d, sp2, opaq);
                opaq = 1'b0;
            end
        end
        if (spp[1] && bgon)
        begin
            if (trm && gp != 2'd2 && tron && gp < tp)
                d = draw_bg_tr(d, bt, flags, sp, bl, opaq);
            else
                d = draw_gated(d, bt, flags, opaq, td, 2'b10);
            td = 1'b1;
            opaq = 1'b0;
        end
        if (tp[1] && ton)
        begin
            if (trm && gp != 2'd2 && tron)
                d = draw_text_tr(d, bt, flags, sp, bl, opaq);
            else
                d = draw_gated(d, bt, flags, opaq, td, 2'b01);
            td = 1'b1;
            opaq = 1'b0;
        end

        // level 1
        if (gp == 2'd1 && gon)
        begin
            d = draw_plain(d, g, opaq);
            opaq = 1'b0;
        end
        if (spp == 2'd1 && bgon)
        begin
            if (trm && gp == 2'd0 && tron && gp < tp)
                d = draw_bg_tr(d, bt, flags, sp, bl, opaq);
            else
                d = draw_gated(d, bt, flags, opaq, tp == 2'd2, 2'b10);
            td = 1'b1;
            opaq = 1'b0;
        end
        if (tp == 2'd1 && trm && gp != 2'd0 && spp > gp && bgon && tron)
        begin
            d = draw_bg_tr(d, bt, flags, sp, bl, opaq);
            td = 1'b1;
            opaq = 1'b0;
            d = draw_plain(d, sp2, opaq);
        end
        else if (gp == 2'd1 && tron && gon && sp2_gate)
        begin
            d = draw_plain(d, sp2, opaq);
            opaq = 1'b0;
        end
        if (tp == 2'd1 && ton)
        begin
            if (trm && gp == 2'd0 && tron)
                d = draw_text_tr(d, bt, flags, sp, bl, opaq);
            else
                d = draw_gated(d, bt, flags, opaq, spp != 2'd0, 2'b01);
            td = 1'b1;
            opaq = 1'b0;
        end

        // level 0
        if (gp == 2'd0 && gon)
        begin
            d = draw_plain(d, g, opaq);
            opaq = 1'b0;
        end
        if (spp == 2'd0 && bgon)
        begin
            d = draw_gated(d, bt, flags, opaq, tp != 2'd0, 2'b10);
            td = 1'b1;
            opaq = 1'b0;
        end
        if (tp == 2'd0 && trm && spp > gp && bgon && tron)
        begin
            d = draw_bg_tr(d, bt, flags, sp, bl, opaq);
            td = 1'b1;
            opaq = 1'b0;
            d = draw_plain(d, sp2, opaq);
        end
        else if (gp == 2'd0 && tron && sp2_gate)
        begin
            d = draw_plain(d, sp2, opaq);
            opaq = 1'b0;
        end
        if (tp == 2'd0 && ton)
        begin
            d = draw_gated(d, bt, flags, opaq, 1'b1, 2'b01);
            td = 1'b1;
            opaq = 1'b0;
        end

        // priority override or half-dim fill
        if (prm && pron)
        begin
            if (sp != '0)
                d = sp;
        end
        else if (dim && tron)
        begin
            if (d == '0 && sp != '0)
                d = (sp & FIELD_LSB_CLEAR) >> 1;
        end

        // nothing drawn
        if (opaq)
            d = '0;
    end

    // zero word expands to zero
    assign pixel = unpack565(d);

endmodule

`default_nettype wire
